>>> rtl/core/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned PADDR_W  = 52;
  localparam int unsigned VADDR_W  = 48;
  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned LVL_W    = 9;
  localparam int unsigned FRAME_W  = PADDR_W - PAGE_W;
  localparam int unsigned WORD_W   = FRAME_W + LVL_W;
  localparam int unsigned LVL_SEL_W = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ         = 2'd1;
  localparam logic [CMD_W-1:0] CMD_XLATE_ROOT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_XLATE_KERNEL = 2'd3;

  localparam logic [LVL_SEL_W-1:0] LVL_PML4 = 2'd0;
  localparam logic [LVL_SEL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LVL_SEL_W-1:0] LVL_PD   = 2'd2;
  localparam logic [LVL_SEL_W-1:0] LVL_PT   = 2'd3;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_READ,
    RES_UNMAPPED,
    RES_MAPPED,
    RES_OOW
  } res_kind_t;

  typedef struct packed {
    logic                 load;
    logic                 mem_wr;
    logic                 mem_rd;
    logic                 rd_walk;
    logic                 use_entry;
    logic [LVL_SEL_W-1:0] lvl;
    logic                 res_load;
    res_kind_t            res_kind;
  } pwt_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             index_ok;
    logic             in_win;
    logic             present;
    logic             out_free;
  } pwt_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/pwt_in_if.sv
// ----------------------------------------------------------------------------
// pwt_in_if
// Command channel: valid/ready with one command item as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwt_in_if import pwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] mem_index;
  logic [DATA_W-1:0]  write_data;
  logic [PADDR_W-1:0] root;
  logic [VADDR_W-1:0] vaddr;

  modport source (output valid, cmd, mem_index, write_data, root, vaddr, input ready);
  modport sink   (input valid, cmd, mem_index, write_data, root, vaddr, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pwt_out_if.sv
// ----------------------------------------------------------------------------
// pwt_out_if
// Result channel: valid/ready with one result item as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwt_out_if import pwt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic [PADDR_W-1:0] paddr;
  logic               mapped;
  logic               out_of_window;

  modport source (output valid, read_data, paddr, mapped, out_of_window, input ready);
  modport sink   (input valid, read_data, paddr, mapped, out_of_window, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pwt_dp.sv
// ----------------------------------------------------------------------------
// pwt_dp
// Datapath: command registers, kernel root, table memory, level index
// selection, window check and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_dp import pwt_pkg::*; #(
  parameter int unsigned TABLE_WORDS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [CMD_W-1:0]   in_cmd,
  input  wire logic [INDEX_W-1:0] in_mem_index,
  input  wire logic [DATA_W-1:0]  in_write_data,
  input  wire logic [PADDR_W-1:0] in_root,
  input  wire logic [VADDR_W-1:0] in_vaddr,
  input  wire logic               cfg_wr_en,
  input  wire logic [PADDR_W-1:0] cfg_wr_data,
  input  wire pwt_cmd_t           cmd_i,
  output pwt_sts_t                sts_o,
  pwt_out_if.source               out_ch
);

  localparam int unsigned AW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;

  logic [DATA_W-1:0]  table_mem [TABLE_WORDS];

  logic [PADDR_W-1:0] kernel_root_r;
  logic [CMD_W-1:0]   op_r;
  logic [INDEX_W-1:0] index_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [VADDR_W-1:0] va_r;
  logic [FRAME_W-1:0] base_r;
  logic [DATA_W-1:0]  rdata_r;

  logic               out_valid_r;
  logic [DATA_W-1:0]  out_rd_r;
  logic [PADDR_W-1:0] out_pa_r;
  logic               out_mapped_r;
  logic               out_oow_r;

  logic [FRAME_W-1:0] table_sel;
  logic [LVL_W-1:0]   lvl_idx;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  index_ext;
  logic [WORD_W-1:0]  addr_full;
  logic [AW-1:0]      addr;
  logic               index_ok;
  logic               in_win;
  logic               out_free;

  always_comb begin
    unique case (cmd_i.lvl)
      LVL_PML4: lvl_idx = va_r[47:39];
      LVL_PDPT: lvl_idx = va_r[38:30];
      LVL_PD:   lvl_idx = va_r[29:21];
      LVL_PT:   lvl_idx = va_r[20:12];
      default:  lvl_idx = '0;
    endcase
  end

  // table base is 4 KiB aligned, so base/8 + index is a plain concatenation
  assign table_sel = cmd_i.use_entry ? rdata_r[PADDR_W-1:PAGE_W] : base_r;
  assign word      = {table_sel, lvl_idx};
  assign in_win    = word < WORD_W'(TABLE_WORDS);
  assign index_ext = WORD_W'(index_r);
  assign index_ok  = index_ext < WORD_W'(TABLE_WORDS);
  assign addr_full = cmd_i.rd_walk ? word : index_ext;
  assign addr      = addr_full[AW-1:0];
  assign out_free  = !out_valid_r || out_ch.ready;

  assign sts_o = '{op: op_r, index_ok: index_ok, in_win: in_win,
                   present: rdata_r[0], out_free: out_free};

  always_ff @(posedge clk) begin
    if (cmd_i.mem_wr && index_ok) begin
      table_mem[addr] <= wdata_r;
    end
    if (cmd_i.mem_rd) begin
      rdata_r <= table_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_root_r <= '0;
    end else if (cfg_wr_en) begin
      kernel_root_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      op_r    <= in_cmd;
      index_r <= in_mem_index;
      wdata_r <= in_write_data;
      va_r    <= in_vaddr;
      base_r  <= (in_cmd == CMD_XLATE_KERNEL) ? kernel_root_r[PADDR_W-1:PAGE_W]
                                              : in_root[PADDR_W-1:PAGE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.res_load) begin
      out_rd_r     <= '0;
      out_pa_r     <= '0;
      out_mapped_r <= 1'b0;
      out_oow_r    <= 1'b0;
      unique case (cmd_i.res_kind)
        RES_READ:   out_rd_r <= index_ok ? rdata_r : '0;
        RES_MAPPED: begin
          out_pa_r     <= {rdata_r[PADDR_W-1:PAGE_W], va_r[PAGE_W-1:0]};
          out_mapped_r <= 1'b1;
        end
        RES_OOW:    out_oow_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_rd_r;
  assign out_ch.paddr         = out_pa_r;
  assign out_ch.mapped        = out_mapped_r;
  assign out_ch.out_of_window = out_oow_r;

endmodule

`default_nettype wire

>>> rtl/core/pwt_ctrl.sv
// ----------------------------------------------------------------------------
// pwt_ctrl
// Controller: sequences entry write/read and the four-level walk, and
// loads the result register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_ctrl import pwt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pwt_sts_t sts_i,
  output pwt_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_READ,
    S_WALK,
    S_LAST
  } state_t;

  state_t               state_r, state_nxt;
  logic [LVL_SEL_W-1:0] lvl_r, lvl_nxt;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    in_ready  = 1'b0;
    cmd_o     = '{load: 1'b0, mem_wr: 1'b0, mem_rd: 1'b0, rd_walk: 1'b0,
                  use_entry: 1'b0, lvl: lvl_r, res_load: 1'b0, res_kind: RES_ZERO};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (sts_i.op)
          CMD_WRITE: begin
            if (sts_i.out_free) begin
              cmd_o.mem_wr   = 1'b1;
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RES_ZERO;
              state_nxt      = S_IDLE;
            end
          end
          CMD_READ: begin
            cmd_o.mem_rd = 1'b1;
            state_nxt    = S_READ;
          end
          default: begin
            cmd_o.lvl = LVL_PML4;
            if (sts_i.in_win) begin
              cmd_o.mem_rd  = 1'b1;
              cmd_o.rd_walk = 1'b1;
              lvl_nxt       = LVL_PDPT;
              state_nxt     = S_WALK;
            end else if (sts_i.out_free) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_kind = RES_OOW;
              state_nxt      = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_READ;
          state_nxt      = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.use_entry = 1'b1;
        priority if (!sts_i.present) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_UNMAPPED;
            state_nxt      = S_IDLE;
          end
        end else if (!sts_i.in_win) begin
          if (sts_i.out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_OOW;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd_o.mem_rd  = 1'b1;
          cmd_o.rd_walk = 1'b1;
          lvl_nxt       = lvl_r + 1'b1;
          if (lvl_r == LVL_PT) begin
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = sts_i.present ? RES_MAPPED : RES_UNMAPPED;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= LVL_PML4;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  a_res_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.res_load |-> sts_i.out_free)
    else $error("result loaded while result register busy");

  a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.rd_walk |-> (sts_i.in_win && cmd_o.mem_rd))
    else $error("walk read outside table window");

  a_no_wr_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_o.mem_wr && cmd_o.mem_rd))
    else $error("table write and read in one cycle");

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ISSUE))
    else $error("accepted command not issued");

  a_last_after_pt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST) |-> ($past(state_r) == S_WALK || $past(state_r) == S_LAST))
    else $error("last level reached out of sequence");

endmodule

`default_nettype wire

>>> rtl/core/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Page table memory with entry write/read and a four-level address walk.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid / ready    | cmd, mem_index, write_data, root, vaddr
//  out_ch  | out | valid / ready    | read_data, paddr, mapped, out_of_window
//  cfg_*   | in  | cfg_wr_en        | cfg_wr_data (kernel_root)
//
// One command at a time. A write stores the entry and a read returns it; a translate whose
// root is outside the window reports out_of_window without a table read, else one table read per level.
// Reset (rst_n, sync) clears control and kernel_root; table memory is kept.
// A held result register stalls only the command that would overwrite it.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker import pwt_pkg::*; #(
  parameter int unsigned TABLE_WORDS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  pwt_in_if.sink                  in_ch,
  pwt_out_if.source               out_ch,
  input  wire logic               cfg_wr_en,
  input  wire logic [PADDR_W-1:0] cfg_wr_data
);

  pwt_cmd_t dp_cmd;
  pwt_sts_t dp_sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  pwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd)
  );

  pwt_dp #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_ch.cmd),
    .in_mem_index  (in_ch.mem_index),
    .in_write_data (in_ch.write_data),
    .in_root       (in_ch.root),
    .in_vaddr      (in_ch.vaddr),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/sv/pwt_xlate_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_xlate_check
// Watches the command and result channels of the page table walker, keeps
// its own copy of table memory and kernel_root, works out the result of each
// command transfer and compares every result transfer with it in order.
// ----------------------------------------------------------------------------
module pwt_xlate_check import pwt_pkg::*; #(
  parameter int unsigned TABLE_WORDS = 8192
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  pwt_in_if                       in_ch,
  pwt_out_if                      out_ch,
  input  wire logic               cfg_wr_en,
  input  wire logic [PADDR_W-1:0] cfg_wr_data,
  output int                      failures,
  output int                      outstanding
);

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [PADDR_W-1:0] paddr;
    logic               mapped;
    logic               out_of_window;
  } xlate_result_t;

  logic [DATA_W-1:0]  entry_mem [TABLE_WORDS];
  logic [PADDR_W-1:0] kernel_root;
  xlate_result_t      pending_results[$];

  initial begin
    failures    = 0;
    outstanding = 0;
    kernel_root = '0;
  end

  function automatic xlate_result_t walk_tables(input logic [PADDR_W-1:0] base,
                                                input logic [VADDR_W-1:0] va);
    xlate_result_t      res;
    logic [PADDR_W-1:0] tbl;
    logic [PADDR_W:0]   word;
    logic [DATA_W-1:0]  entry;
    res = '0;
    tbl = {base[PADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
    for (int lvl = 0; lvl < 4; lvl++) begin
      word = (tbl >> 3) + va[PAGE_W + LVL_W * (3 - lvl) +: LVL_W];
      if (word >= TABLE_WORDS) begin
        res.out_of_window = 1'b1;
        return res;
      end
      entry = entry_mem[word];
      if (!entry[0])
        return res;
      tbl = {entry[PADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
    end
    res.paddr  = {tbl[PADDR_W-1:PAGE_W], va[PAGE_W-1:0]};
    res.mapped = 1'b1;
    return res;
  endfunction

  function automatic xlate_result_t predict_result(input logic [CMD_W-1:0]   cmd,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [DATA_W-1:0]  data,
                                                   input logic [PADDR_W-1:0] root,
                                                   input logic [VADDR_W-1:0] va);
    xlate_result_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        if (idx < TABLE_WORDS)
          entry_mem[idx] = data;
      end
      CMD_READ: begin
        if (idx < TABLE_WORDS)
          res.read_data = entry_mem[idx];
      end
      CMD_XLATE_ROOT: res = walk_tables(root, va);
      default:        res = walk_tables(kernel_root, va);
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10)
      $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    xlate_result_t want;
    xlate_result_t got;
    if (!rst_n) begin
      kernel_root = '0;
      pending_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.read_data     = out_ch.read_data;
        got.paddr         = out_ch.paddr;
        got.mapped        = out_ch.mapped;
        got.out_of_window = out_ch.out_of_window;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result transfer with nothing pending: rd %h pa %h m %b oow %b",
                                 got.read_data, got.paddr, got.mapped,
                                 got.out_of_window));
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data || got.paddr !== want.paddr ||
              got.mapped !== want.mapped || got.out_of_window !== want.out_of_window)
            note_failure($sformatf({"result mismatch (exp/got): rd %h/%h pa %h/%h",
                                    " m %b/%b oow %b/%b"},
                                   want.read_data, got.read_data,
                                   want.paddr, got.paddr,
                                   want.mapped, got.mapped,
                                   want.out_of_window, got.out_of_window));
        end
      end
      if (cfg_wr_en)
        kernel_root = cfg_wr_data;
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(predict_result(in_ch.cmd, in_ch.mem_index,
                                                 in_ch.write_data, in_ch.root,
                                                 in_ch.vaddr));
    end
    outstanding = pending_results.size();
  end

endmodule

>>> tb/sv/four_level_page_table_walker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_test
// Drives entry writes, reads and four-level walks into the walker, building
// well-formed table chains with random content so that most walks go deep,
// mixed with stray writes and out-of-window roots. kernel_root is changed
// between phases while the block is idle. Results are checked by
// pwt_xlate_check; the receiver stalls on its own pattern, now and then for long.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_test;
  import pwt_pkg::*;

  localparam int unsigned TABLE_WORDS = 8192;
  localparam int unsigned TABLE_PAGES = TABLE_WORDS / (1 << LVL_W);
  localparam int          PHASE_ITEMS = 260;
  localparam int          QUIET_LIMIT = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [PADDR_W-1:0] cfg_wr_data;
  int                 failures;
  int                 outstanding;

  pwt_in_if  in_ch ();
  pwt_out_if out_ch ();

  four_level_page_table_walker #(.TABLE_WORDS(TABLE_WORDS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pwt_xlate_check #(.TABLE_WORDS(TABLE_WORDS)) xlate_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // stimulus-side view of memory, used only to keep walks on written entries
  logic [DATA_W-1:0]  shadow [TABLE_WORDS];
  bit                 filled [TABLE_WORDS];
  int                 filled_list[$];
  logic [VADDR_W-1:0] va_pool[$];
  logic [PADDR_W-1:0] kroot;
  int                 sent;
  int                 burst_left;
  int                 quiet_cycles;

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_WRITE;
    in_ch.mem_index = '0;
    in_ch.write_data = '0;
    in_ch.root      = '0;
    in_ch.vaddr     = '0;
    kroot           = '0;
    sent            = 0;
    burst_left      = 0;
    quiet_cycles    = 0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[four_level_page_table_walker] ERROR");
      $finish;
    end
  end

  // result side: stall pattern of its own, with a long hold-off now and then
  initial begin
    int seg;
    int span;
    int mode;
    seg = 0;
    out_ch.ready = 1'b0;
    forever begin
      seg++;
      if (seg == 4 || seg % 60 == 0) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(10, 150);
        repeat (span) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ($urandom_range(0, 9) == 0);
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PADDR_W-1:0] rand52();
    logic [DATA_W-1:0] v;
    v = rand64();
    return v[PADDR_W-1:0];
  endfunction

  function automatic logic [VADDR_W-1:0] rand48();
    logic [DATA_W-1:0] v;
    v = rand64();
    return v[VADDR_W-1:0];
  endfunction

  function automatic logic [PADDR_W-1:0] pick_root();
    logic [PADDR_W-1:0] r;
    r = rand52();
    case ($urandom_range(0, 15))
      0, 1:    ;
      2:       r[PADDR_W-1:PAGE_W] = FRAME_W'(TABLE_PAGES - 1);
      default: r[PADDR_W-1:PAGE_W] = FRAME_W'($urandom_range(0, TABLE_PAGES - 1));
    endcase
    return r;
  endfunction

  function automatic logic [VADDR_W-1:0] pick_va();
    logic [VADDR_W-1:0] va;
    int                 lvl;
    if (va_pool.size() != 0 && $urandom_range(0, 1) == 1) begin
      va = va_pool[$urandom_range(0, va_pool.size() - 1)];
      va[PAGE_W-1:0] = PAGE_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        lvl = $urandom_range(0, 3);
        va[PAGE_W + LVL_W * lvl +: LVL_W] = LVL_W'($urandom);
      end
    end else begin
      va = rand48();
      va_pool.push_back(va);
      if (va_pool.size() > 64)
        void'(va_pool.pop_front());
    end
    return va;
  endfunction

  // upper levels mostly point inside the window, last level anywhere
  function automatic logic [DATA_W-1:0] make_entry(input int lvl);
    logic [DATA_W-1:0] e;
    int                r;
    e = rand64();
    r = $urandom_range(0, 15);
    e[0] = (r != 0);
    if (lvl < 3) begin
      if (r == 1)
        e[PADDR_W-1:PAGE_W] = FRAME_W'(TABLE_PAGES);
      else if (r != 2)
        e[PADDR_W-1:PAGE_W] = FRAME_W'($urandom_range(0, TABLE_PAGES - 1));
    end
    return e;
  endfunction

  // first never-written entry a walk would read, -1 if none
  function automatic int blank_on_path(input logic [PADDR_W-1:0] base,
                                       input logic [VADDR_W-1:0] va, output int lvl);
    logic [PADDR_W-1:0] tbl;
    logic [PADDR_W:0]   word;
    tbl = {base[PADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
    for (lvl = 0; lvl < 4; lvl++) begin
      word = (tbl >> 3) + va[PAGE_W + LVL_W * (3 - lvl) +: LVL_W];
      if (word >= TABLE_WORDS)
        return -1;
      if (!filled[word])
        return int'(word);
      if (!shadow[word][0])
        return -1;
      tbl = {shadow[word][PADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
    end
    return -1;
  endfunction

  task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                          input logic [DATA_W-1:0] data, input logic [PADDR_W-1:0] root,
                          input logic [VADDR_W-1:0] va);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.mem_index  <= idx;
    in_ch.write_data <= data;
    in_ch.root       <= root;
    in_ch.vaddr      <= va;
    do
      @(posedge clk);
    while (!in_ch.ready);
    sent++;
    if (cmd == CMD_WRITE) begin
      if (!filled[idx]) begin
        filled[idx] = 1'b1;
        filled_list.push_back(int'(idx));
      end
      shadow[idx] = data;
    end
  endtask

  task automatic write_entry(input int idx, input logic [DATA_W-1:0] data);
    put_item(CMD_WRITE, idx[INDEX_W-1:0], data, rand52(), rand48());
  endtask

  task automatic read_entry(input int idx);
    put_item(CMD_READ, idx[INDEX_W-1:0], rand64(), rand52(), rand48());
  endtask

  task automatic translate(input logic [CMD_W-1:0] cmd, input logic [PADDR_W-1:0] root,
                           input logic [VADDR_W-1:0] va);
    logic [PADDR_W-1:0] base;
    int                 word;
    int                 lvl;
    base = (cmd == CMD_XLATE_ROOT) ? root : kroot;
    word = blank_on_path(base, va, lvl);
    while (word >= 0) begin
      write_entry(word, make_entry(lvl));
      word = blank_on_path(base, va, lvl);
    end
    put_item(cmd, INDEX_W'($urandom_range(0, TABLE_WORDS - 1)), rand64(), root, va);
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      translate(CMD_XLATE_ROOT, pick_root(), pick_va());
    else if (r < 55)
      translate(CMD_XLATE_KERNEL, rand52(), pick_va());
    else if (r < 70)
      read_entry(filled_list[$urandom_range(0, filled_list.size() - 1)]);
    else if (r < 85)
      write_entry(filled_list[$urandom_range(0, filled_list.size() - 1)],
                  make_entry($urandom_range(0, 3)));
    else
      write_entry($urandom_range(0, TABLE_WORDS - 1), rand64());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do
      @(negedge clk);
    while (outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_kernel_root(input logic [PADDR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    kroot = value;
  endtask

  initial begin
    logic [VADDR_W-1:0] va_full;
    logic [VADDR_W-1:0] va_hole;
    logic [PADDR_W-1:0] kr;
    int                 target;
    va_full = {9'd5, 9'd6, 9'd7, 9'd8, 12'habc};
    va_hole = {9'd5, 9'd6, 9'd7, 9'd9, 12'h000};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_kernel_root(52'h0_0000_0000_1fff);

    // directed: extremes of index and data, a hand-built chain, window edges
    write_entry(0, '1);
    write_entry(TABLE_WORDS - 1, '0);
    read_entry(0);
    read_entry(TABLE_WORDS - 1);
    translate(CMD_XLATE_ROOT, '0, '0);
    write_entry(512 + 5, 64'hfff0_0000_0000_2081);
    write_entry(2 * 512 + 6, 64'h0000_0000_0000_4fff);
    write_entry(4 * 512 + 7, 64'h0000_0000_0000_5081);
    write_entry(5 * 512 + 8, 64'h000f_ffff_ffff_f001);
    write_entry(5 * 512 + 9, 64'h000f_ffff_ffff_f000);
    translate(CMD_XLATE_ROOT, 52'h0_0000_0000_1123, va_full);
    translate(CMD_XLATE_KERNEL, '0, va_full);
    translate(CMD_XLATE_ROOT, 52'h0_0000_0000_1000, va_hole);
    translate(CMD_XLATE_KERNEL, '1, va_hole);
    translate(CMD_XLATE_ROOT, '1, rand48());
    translate(CMD_XLATE_ROOT, {40'd15, 12'h000}, {9'd511, 39'd0});
    translate(CMD_XLATE_ROOT, {40'd3, 12'hfff}, '1);
    read_entry(512 + 5);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       kr = '0;
        1:       kr = '1;
        2:       kr = {28'd0, 12'($urandom_range(0, TABLE_PAGES - 1)), 12'($urandom)};
        default: kr = {40'(TABLE_PAGES - 1), 12'hfff};
      endcase
      set_kernel_root(kr);
      target = sent + PHASE_ITEMS;
      while (sent < target)
        random_op();
      drain();
    end

    if (failures == 0 && outstanding == 0)
      $display("[four_level_page_table_walker] OK");
    else
      $display("[four_level_page_table_walker] ERROR");
    $finish;
  end

endmodule
